>>> hdl/mme_pkg.sv
// Shared constants and types for the matrix multiply engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package mme_pkg;

    // Default largest matrix dimension.
    localparam int MAX_DIM_DEF = 8;

    // Element, product and sum widths (Q8.8 in, Q16.16 product, Q19.16 sum out).
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 35;

    // Configuration port.
    localparam int DIM_REG_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int REG_COUNT = 4;

    // Row and column index ports.
    localparam int ROWCOL_W = 3;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Result status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_ROWS = 3'd0,
        REG_A_COLS = 3'd1,
        REG_B_ROWS = 3'd2,
        REG_B_COLS = 3'd3
    } t_reg_index;

endpackage

`default_nettype wire

>>> hdl/matrix_multiply_engine.sv
// Matrix multiply engine (P = A x B, Q8.8 in, Q19.16 out).
// Top level: ties mme_front, mme_queue and mme_back; depends on mme_pkg.
//
// Usage:
//   Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
//   sets rows/cols of A and B; it is always ready. Write it only while idle;
//   any write to a valid index restarts the load. All dimensions reset to 8.
//   Input channel (i_in_valid/o_in_ready) moves one element per transfer:
//   A row-major, then B row-major. Loading takes one element per cycle while
//   the four-entry command queue has room.
//   After the last element of B, the back end runs one multiply-accumulate
//   per cycle while the result register is not stalled, with results in
//   row-major order and o_last on the final one.
//   While the MAC loop runs it takes no new commands, so loading of the next
//   run proceeds only until the queue is full. The single MAC unit sets the
//   pace of a run. Inner dimension mismatch gives one result with o_status
//   set and o_last high.
//   Output channel (o_out_valid/i_out_ready) holds each result in a register;
//   when the receiver stalls, the MAC pipeline freezes and nothing is lost.
//   Reset (i_rst_n low, synchronous) empties the queue and pipeline.
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_REG_W-1:0] i_cfg_data,
    // elements
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ELEM_W-1:0]    i_element_value,
    // results
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ACC_W-1:0]          o_product_value,
    output logic [ROWCOL_W-1:0]       o_result_row,
    output logic [ROWCOL_W-1:0]       o_result_col,
    output logic                      o_status,
    output logic                      o_last
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int ENTRY_W = 2 + ADDR_W + ELEM_W;

    logic               q_space, q_push, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_wr_data, q_rd_data;
    logic [DIM_W-1:0]   a_rows, a_cols, b_rows, b_cols;

    // Accept and classify elements.
    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .i_q_space       (q_space),
        .o_q_push        (q_push),
        .o_q_data        (q_wr_data),
        .o_a_rows        (a_rows),
        .o_a_cols        (a_cols),
        .o_b_rows        (b_rows),
        .o_b_cols        (b_cols)
    );

    // Buffer commands between the two sides.
    mme_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rd_data)
    );

    // Store elements and compute the product.
    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_data        (q_rd_data),
        .i_a_rows        (a_rows),
        .i_a_cols        (a_cols),
        .i_b_rows        (b_rows),
        .i_b_cols        (b_cols),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

>>> hdl/mme_front.sv
// Front end: configuration registers, element load counter and classifier.
// Depends on mme_pkg; feeds store-write commands into mme_queue.
`default_nettype none

module mme_front import mme_pkg::*; #(
    parameter int  MAX_DIM = MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
    localparam int CNT_W   = $clog2(2 * MAX_DIM * MAX_DIM + 1),
    localparam int ENTRY_W = 2 + ADDR_W + ELEM_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_REG_W-1:0] i_cfg_data,
    // element input
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ELEM_W-1:0]    i_element_value,
    // command queue write side
    input  wire logic                 i_q_space,
    output logic                      o_q_push,
    output logic [ENTRY_W-1:0]        o_q_data,
    // effective dimensions
    output logic [DIM_W-1:0]          o_a_rows,
    output logic [DIM_W-1:0]          o_a_cols,
    output logic [DIM_W-1:0]          o_b_rows,
    output logic [DIM_W-1:0]          o_b_cols
);

    logic [DIM_REG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 cfg_hit, accept, is_b, run_end;
    logic [CNT_W-1:0]     num_a, total, b_off, cnt_inc;

    // Clamp a raw dimension into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] raw);
        logic [DIM_W-1:0] res;
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (32'(raw) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(raw);
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT));

    // Hold the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_REG_W'(8);
            r_a_cols <= DIM_REG_W'(8);
            r_b_rows <= DIM_REG_W'(8);
            r_b_cols <= DIM_REG_W'(8);
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_A_ROWS: r_a_rows <= i_cfg_data;
                REG_A_COLS: r_a_cols <= i_cfg_data;
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_a_rows = clamp_dim(r_a_rows);
    assign o_a_cols = clamp_dim(r_a_cols);
    assign o_b_rows = clamp_dim(r_b_rows);
    assign o_b_cols = clamp_dim(r_b_cols);

    // Classify the element by its place in the run.
    assign num_a   = CNT_W'(o_a_rows) * CNT_W'(o_a_cols);
    assign total   = num_a + CNT_W'(o_b_rows) * CNT_W'(o_b_cols);
    assign is_b    = (r_cnt >= num_a);
    assign b_off   = r_cnt - num_a;
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign run_end = (cnt_inc >= total);

    assign o_in_ready = i_q_space;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept;
    assign o_q_data   = {is_b, run_end,
                         is_b ? b_off[ADDR_W-1:0] : r_cnt[ADDR_W-1:0],
                         i_element_value};

    // Advance the load count; drop a partial load on a register write.
    always_comb begin
        n_cnt = r_cnt;
        if (cfg_hit) begin
            n_cnt = '0;
        end else if (accept) begin
            n_cnt = run_end ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mme_queue.sv
// Short command queue between the front end and the compute back end.
// Depends on mme_pkg for its depth.
`default_nettype none

module mme_queue import mme_pkg::*; #(
    parameter int WIDTH = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_space = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    // Store the pushed entry.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/mme_back.sv
// Back end: element stores, multiply-accumulate pipeline and result register.
// Depends on mme_pkg; takes store-write commands from mme_queue.
`default_nettype none

module mme_back import mme_pkg::*; #(
    parameter int  MAX_DIM = MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ENTRY_W = 2 + ADDR_W + ELEM_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command queue read side
    input  wire logic               i_q_valid,
    output logic                    o_q_pop,
    input  wire logic [ENTRY_W-1:0] i_q_data,
    // effective dimensions
    input  wire logic [DIM_W-1:0]   i_a_rows,
    input  wire logic [DIM_W-1:0]   i_a_cols,
    input  wire logic [DIM_W-1:0]   i_b_rows,
    input  wire logic [DIM_W-1:0]   i_b_cols,
    // results
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [ACC_W-1:0]        o_product_value,
    output logic [ROWCOL_W-1:0]     o_result_row,
    output logic [ROWCOL_W-1:0]     o_result_col,
    output logic                    o_status,
    output logic                    o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_ERR  = 3'b100
    } t_state;

    // Per-stage tag of one multiply-accumulate step.
    typedef struct packed {
        logic                vld;
        logic                first;
        logic                last;
        logic                run_end;
        logic                err;
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
    } t_tag;

    logic [ELEM_W-1:0] a_mem [DEPTH];
    logic [ELEM_W-1:0] b_mem [DEPTH];

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_i, r_j, r_k, n_i, n_j, n_k;
    logic [ADDR_W-1:0]   r_a_base, r_a_addr, r_b_addr, n_a_base, n_a_addr, n_b_addr;
    t_tag                s0_tag, r_s1, r_s2;
    logic [ELEM_W-1:0]   r_a_rd, r_b_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, w_sum;

    logic                r_out_vld;
    logic [ACC_W-1:0]    r_out_value;
    logic [ROWCOL_W-1:0] r_out_row, r_out_col;
    logic                r_out_status, r_out_last;

    logic                en, issue, k_last, j_last, i_last, finish;
    logic                q_is_b, q_run_end;
    logic [ADDR_W-1:0]   q_addr;
    logic [ELEM_W-1:0]   q_value;

    // Unpack the queue head.
    assign {q_is_b, q_run_end, q_addr, q_value} = i_q_data;
    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    // Stall the pipeline while a finished sum cannot enter the result register.
    assign en     = !(r_s2.vld && r_s2.last && r_out_vld && !i_out_ready);
    assign issue  = ((r_state == ST_RUN) || (r_state == ST_ERR)) && en;
    assign finish = en && r_s2.vld && r_s2.last;

    assign k_last = (DIM_W'(r_k) + DIM_W'(1) == i_a_cols);
    assign j_last = (DIM_W'(r_j) + DIM_W'(1) == i_b_cols);
    assign i_last = (DIM_W'(r_i) + DIM_W'(1) == i_a_rows);

    // Tag of the step issued this cycle.
    always_comb begin
        s0_tag.vld     = issue;
        s0_tag.first   = (r_k == '0);
        s0_tag.err     = (r_state == ST_ERR);
        s0_tag.last    = s0_tag.err || k_last;
        s0_tag.run_end = s0_tag.err || (i_last && j_last);
        s0_tag.row     = ROWCOL_W'(r_i);
        s0_tag.col     = ROWCOL_W'(r_j);
    end

    // Sequence rows, columns and the inner index.
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a_base = r_a_base;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        case (r_state)
            ST_IDLE: begin
                if (o_q_pop && q_run_end) begin
                    n_state  = (i_a_cols != i_b_rows) ? ST_ERR : ST_RUN;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_a_base = '0;
                    n_a_addr = '0;
                    n_b_addr = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (k_last) begin
                        n_k = '0;
                        if (j_last) begin
                            n_j      = '0;
                            n_i      = r_i + IDX_W'(1);
                            n_a_base = r_a_base + ADDR_W'(i_a_cols);
                            n_a_addr = r_a_base + ADDR_W'(i_a_cols);
                            n_b_addr = '0;
                            if (i_last) begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_j      = r_j + IDX_W'(1);
                            n_a_addr = r_a_base;
                            n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
                        end
                    end else begin
                        n_k      = r_k + IDX_W'(1);
                        n_a_addr = r_a_addr + ADDR_W'(1);
                        n_b_addr = r_b_addr + ADDR_W'(i_b_cols);
                    end
                end
            end
            ST_ERR: begin
                if (issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_a_base <= n_a_base;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
    end

    // Write loaded elements into the stores.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && !q_is_b) begin
            a_mem[q_addr] <= q_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && q_is_b) begin
            b_mem[q_addr] <= q_value;
        end
    end

    // Read both operands.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rd <= a_mem[r_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rd <= b_mem[r_b_addr];
        end
    end

    // Advance the stage tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (en) begin
            r_s1 <= s0_tag;
            r_s2 <= r_s1;
        end
    end

    // Multiply.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= $signed(r_a_rd) * $signed(r_b_rd);
        end
    end

    // Accumulate.
    assign w_sum = (r_s2.first ? '0 : r_acc)
                 + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (en && r_s2.vld) begin
            r_acc <= w_sum;
        end
    end

    // Hold the finished result until it is transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_value  <= r_s2.err ? '0 : w_sum;
            r_out_row    <= r_s2.row;
            r_out_col    <= r_s2.col;
            r_out_status <= r_s2.err ? STATUS_MISMATCH : STATUS_OK;
            r_out_last   <= r_s2.run_end;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_product_value = r_out_value;
    assign o_result_row    = r_out_row;
    assign o_result_col    = r_out_col;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire
